### rtl/chdf_pkg.sv
// ============================================================================
// chdf_pkg
// Shared types, codes and helpers for the chunked body deframer.
// ============================================================================
`default_nettype none

package chdf_pkg;

    // Default width of the chunk size accumulator
    localparam int SIZE_BITS_DEFAULT = 32;

    // Bytes skipped after the data of each chunk
    localparam logic [1:0] SKIP_COUNT = 2'd2;

    // Framing characters
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SIZE = 3'd0,
        PH_LF   = 3'd1,
        PH_DATA = 3'd2,
        PH_SKIP = 3'd3,
        PH_DONE = 3'd4,
        PH_ERR  = 3'd5
    } phase_t;

    // Result kind
    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_END  = 2'd1,
        K_ERR  = 2'd2,
        K_OVF  = 2'd3
    } kind_t;

    // One result word from the parser
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       chunk_last;
    } chdf_result_t;

    // Hex digit decode: bit 4 is set for a hex digit of either case
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/chdf_if.sv
// ============================================================================
// chdf_if
// Valid/ready channels for body bytes in and deframed results out.
// ============================================================================
`default_nettype none

interface chdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       start_body;

    modport source (output valid, output body_byte, output start_body, input ready);
    modport sink   (input valid, input body_byte, input start_body, output ready);
endinterface

interface chdf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       chunk_last;

    modport source (output valid, output kind, output payload_byte, output chunk_last,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input chunk_last,
                    output ready);
endinterface

`default_nettype wire

### rtl/chdf_parser.sv
// ============================================================================
// chdf_parser
// Chunk framing state machine: size line, data, trailer skip, end and error.
// ============================================================================
`default_nettype none

module chdf_parser #(
    parameter int SIZE_BITS = chdf_pkg::SIZE_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           body_byte,
    input  wire logic                 start_body,
    input  wire logic                 chunked_enable,
    output chdf_pkg::chdf_result_t    result
);

    chdf_pkg::phase_t     phase_reg, phase_next, phase_cur;
    logic [SIZE_BITS-1:0] size_acc_reg, size_acc_next, size_acc_cur;
    logic [SIZE_BITS-1:0] remaining_reg, remaining_next, remaining_cur;
    logic                 digit_seen_reg, digit_seen_next, digit_seen_cur;
    logic                 in_ext_reg, in_ext_next, in_ext_cur;
    logic [1:0]           skip_left_reg, skip_left_next, skip_left_cur;
    logic [4:0]           hex;
    logic                 size_full;
    logic                 data_last;
    logic [1:0]           skip_dec;

    // Apply a new-body reset ahead of the byte
    always_comb
    begin
        if (start_body) begin
            phase_cur      = chdf_pkg::PH_SIZE;
            size_acc_cur   = '0;
            remaining_cur  = '0;
            digit_seen_cur = 1'b0;
            in_ext_cur     = 1'b0;
            skip_left_cur  = 2'd0;
        end
        else begin
            phase_cur      = phase_reg;
            size_acc_cur   = size_acc_reg;
            remaining_cur  = remaining_reg;
            digit_seen_cur = digit_seen_reg;
            in_ext_cur     = in_ext_reg;
            skip_left_cur  = skip_left_reg;
        end
    end

    assign hex       = chdf_pkg::hex_decode(body_byte);
    assign size_full = (size_acc_cur[SIZE_BITS-1 -: 4] != 4'd0);
    assign data_last = (remaining_cur <= SIZE_BITS'(1));
    assign skip_dec  = (skip_left_cur != 2'd0) ? skip_left_cur - 2'd1 : 2'd0;

    // Next state
    always_comb
    begin
        phase_next      = phase_cur;
        size_acc_next   = size_acc_cur;
        remaining_next  = remaining_cur;
        digit_seen_next = digit_seen_cur;
        in_ext_next     = in_ext_cur;
        skip_left_next  = skip_left_cur;
        if (chunked_enable) begin
            unique case (phase_cur)
                chdf_pkg::PH_SIZE:
                begin
                    priority if (body_byte == chdf_pkg::CHAR_CR) begin
                        phase_next = digit_seen_cur ? chdf_pkg::PH_LF : chdf_pkg::PH_ERR;
                    end
                    else if (in_ext_cur) begin
                        phase_next = phase_cur;
                    end
                    else if (body_byte == chdf_pkg::CHAR_SEMI) begin
                        in_ext_next = 1'b1;
                    end
                    else if (!hex[4] || size_full) begin
                        phase_next = chdf_pkg::PH_ERR;
                    end
                    else begin
                        size_acc_next   = {size_acc_cur[SIZE_BITS-5:0], hex[3:0]};
                        digit_seen_next = 1'b1;
                    end
                end
                chdf_pkg::PH_LF:
                begin
                    priority if (body_byte != chdf_pkg::CHAR_LF) begin
                        phase_next = chdf_pkg::PH_ERR;
                    end
                    else if (size_acc_cur == '0) begin
                        phase_next = chdf_pkg::PH_DONE;
                    end
                    else begin
                        remaining_next = size_acc_cur;
                        phase_next     = chdf_pkg::PH_DATA;
                    end
                end
                chdf_pkg::PH_DATA:
                begin
                    if (remaining_cur != '0) begin
                        remaining_next = remaining_cur - SIZE_BITS'(1);
                    end
                    if (data_last) begin
                        phase_next     = chdf_pkg::PH_SKIP;
                        skip_left_next = chdf_pkg::SKIP_COUNT;
                    end
                end
                chdf_pkg::PH_SKIP:
                begin
                    skip_left_next = skip_dec;
                    if (skip_dec == 2'd0) begin
                        phase_next      = chdf_pkg::PH_SIZE;
                        size_acc_next   = '0;
                        digit_seen_next = 1'b0;
                        in_ext_next     = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase
        end
    end

    // Result word
    always_comb
    begin
        result              = '0;
        result.kind         = chdf_pkg::K_DATA;
        if (!chunked_enable) begin
            result.valid        = 1'b1;
            result.payload_byte = body_byte;
        end
        else begin
            unique case (phase_cur)
                chdf_pkg::PH_SIZE:
                begin
                    priority if (body_byte == chdf_pkg::CHAR_CR) begin
                        if (!digit_seen_cur) begin
                            result.valid = 1'b1;
                            result.kind  = chdf_pkg::K_ERR;
                        end
                    end
                    else if (in_ext_cur || body_byte == chdf_pkg::CHAR_SEMI) begin
                        result.valid = 1'b0;
                    end
                    else if (!hex[4]) begin
                        result.valid = 1'b1;
                        result.kind  = chdf_pkg::K_ERR;
                    end
                    else if (size_full) begin
                        result.valid = 1'b1;
                        result.kind  = chdf_pkg::K_OVF;
                    end
                    else begin
                        result.valid = 1'b0;
                    end
                end
                chdf_pkg::PH_LF:
                begin
                    priority if (body_byte != chdf_pkg::CHAR_LF) begin
                        result.valid = 1'b1;
                        result.kind  = chdf_pkg::K_ERR;
                    end
                    else if (size_acc_cur == '0) begin
                        result.valid = 1'b1;
                        result.kind  = chdf_pkg::K_END;
                    end
                    else begin
                        result.valid = 1'b0;
                    end
                end
                chdf_pkg::PH_DATA:
                begin
                    result.valid        = 1'b1;
                    result.payload_byte = body_byte;
                    result.chunk_last   = data_last;
                end
                default:
                begin
                    result.valid = 1'b0;
                end
            endcase
        end
        if (!step) begin
            result.valid = 1'b0;
        end
    end

    // Hold parse state, advance on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= chdf_pkg::PH_SIZE;
            size_acc_reg   <= '0;
            remaining_reg  <= '0;
            digit_seen_reg <= 1'b0;
            in_ext_reg     <= 1'b0;
            skip_left_reg  <= 2'd0;
        end
        else if (step) begin
            phase_reg      <= phase_next;
            size_acc_reg   <= size_acc_next;
            remaining_reg  <= remaining_next;
            digit_seen_reg <= digit_seen_next;
            in_ext_reg     <= in_ext_next;
            skip_left_reg  <= skip_left_next;
        end
    end

endmodule

`default_nettype wire

### rtl/http_chunked_body_deframer.sv
// ============================================================================
// http_chunked_body_deframer
// Strips HTTP/1.1 chunked framing from a byte stream, or passes it through.
// ============================================================================
//
//  channel        dir  handshake     payload
//  in_ch          in   valid/ready   body_byte[7:0], start_body
//  out_ch         out  valid/ready   kind[1:0], payload_byte[7:0], chunk_last
//  cfg            in   write enable  chunked_enable_write, chunked_enable
//
//  One byte per cycle sustained while the output is not stalled; each byte
//  is held in the input register, and its result, if any, is loaded
//  into the result register by the single-pass parser update between them.
//  Reset clears both registers' valid flags, the parse state and sets
//  chunked mode on. A stalled output holds the result; the input register
//  keeps accepting while the result register frees up in the same cycle.
// ============================================================================
`default_nettype none

module http_chunked_body_deframer #(
    parameter int SIZE_BITS = chdf_pkg::SIZE_BITS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    chdf_in_if.sink       in_ch,
    chdf_out_if.source    out_ch,
    input  wire logic     chunked_enable_write,
    input  wire logic     chunked_enable
);

    logic                   chunked_enable_reg;
    logic                   s1_valid_reg, s1_valid_next;
    logic [7:0]             s1_byte_reg;
    logic                   s1_start_reg;
    logic                   s1_advance;
    logic                   in_fire;
    chdf_pkg::chdf_result_t parse_res;
    logic                   res_valid_reg;
    logic [1:0]             res_kind_reg;
    logic [7:0]             res_byte_reg;
    logic                   res_last_reg;

    assign s1_advance  = s1_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        priority if (in_fire) begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
        else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chunked_enable_reg <= 1'b1;
        end
        else if (chunked_enable_write) begin
            chunked_enable_reg <= chunked_enable;
        end
    end

    // Capture the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_byte_reg  <= in_ch.body_byte;
            s1_start_reg <= in_ch.start_body;
        end
    end

    chdf_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_advance),
        .body_byte      (s1_byte_reg),
        .start_body     (s1_start_reg),
        .chunked_enable (chunked_enable_reg),
        .result         (parse_res)
    );

    // Load the result register, drop a taken word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_advance) begin
            res_valid_reg <= parse_res.valid;
        end
        else if (out_ch.ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance) begin
            res_kind_reg <= parse_res.kind;
            res_byte_reg <= parse_res.payload_byte;
            res_last_reg <= parse_res.chunk_last;
        end
    end

    assign out_ch.valid        = res_valid_reg;
    assign out_ch.kind         = res_kind_reg;
    assign out_ch.payload_byte = res_byte_reg;
    assign out_ch.chunk_last   = res_last_reg;

endmodule

`default_nettype wire
